>>> design/spc_pkg.sv
// Shared types and constants for the shortest path cost core.
`timescale 1ns / 1ps
package spc_pkg;

  localparam int SPC_MAX_VERTICES = 64;
  localparam logic [15:0] SPC_NO_EDGE = 16'hFFFF;
  localparam logic [23:0] SPC_COST_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CLEAR = 2'd2
  } spc_func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD2,
    S_INIT,
    S_SCAN_GO,
    S_SCAN,
    S_RELAX,
    S_FINISH
  } spc_state_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic        init;
    logic        relax;
    logic [15:0] pick_len;
    logic [23:0] pick_cost;
  } spc_ctl_t;

  // Minimum-search token that travels down the cell chain
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [15:0] low;
    logic [23:0] cost;
  } spc_tok_t;

endpackage

>>> design/spc_mem.sv
// Adjacency row memory for edge length and cost, with per-row valid bits.
`timescale 1ns / 1ps
module spc_mem import spc_pkg::*; #(
  parameter int MAX_VERTICES = SPC_MAX_VERTICES,
  localparam int VW = $clog2(MAX_VERTICES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          wr_en,
  input  logic [VW-1:0] wr_row,
  input  logic [VW-1:0] wr_col,
  input  logic [15:0]   wr_len,
  input  logic [15:0]   wr_cost,
  input  logic [VW-1:0] rd_row,
  output logic [15:0]   rd_len  [MAX_VERTICES],
  output logic [15:0]   rd_cost [MAX_VERTICES]
);

  logic [MAX_VERTICES*32-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]    row_valid_r;
  logic [MAX_VERTICES*32-1:0] rd_q_r;
  logic                       rd_valid_r;

  // Write one entry; a fresh row is filled with the no-edge mark around it
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int c = 0; c < MAX_VERTICES; c++) begin
        if (VW'(c) == wr_col) begin
          mem[wr_row][c*32 +: 32] <= {wr_len, wr_cost};
        end else if (!row_valid_r[wr_row]) begin
          mem[wr_row][c*32 +: 32] <= {SPC_NO_EDGE, SPC_NO_EDGE};
        end
      end
    end
    rd_q_r     <= mem[rd_row];
    rd_valid_r <= row_valid_r[rd_row];
  end

  // Track rows holding written data; clear drops them all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (clr) begin
      row_valid_r <= '0;
    end else if (wr_en) begin
      row_valid_r[wr_row] <= 1'b1;
    end
  end

  // Unpack the row; an unwritten row reads as no edges
  always_comb begin
    for (int c = 0; c < MAX_VERTICES; c++) begin
      rd_len[c]  = rd_valid_r ? rd_q_r[c*32+16 +: 16] : SPC_NO_EDGE;
      rd_cost[c] = rd_valid_r ? rd_q_r[c*32 +: 16]    : SPC_NO_EDGE;
    end
  end

endmodule

>>> design/spc_cell.sv
// One vertex cell: holds best length, cost and done flag, relaxes and passes the token.
`timescale 1ns / 1ps
module spc_cell import spc_pkg::*; #(
  parameter int MAX_VERTICES = SPC_MAX_VERTICES,
  parameter int CELL_IDX = 0,
  localparam int VW = $clog2(MAX_VERTICES),
  localparam int CW = $clog2(MAX_VERTICES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  spc_ctl_t      ctl,
  input  logic [VW-1:0] src,
  input  logic [VW-1:0] pick_idx,
  input  logic [CW-1:0] n_active,
  input  logic [15:0]   edge_len,
  input  logic [15:0]   edge_cost,
  input  spc_tok_t      tok_i,
  input  logic [VW-1:0] tok_idx_i,
  output spc_tok_t      tok_o,
  output logic [VW-1:0] tok_idx_o,
  output logic [15:0]   len_o,
  output logic [23:0]   cost_o
);

  logic [15:0]   len_r, len_nxt;
  logic [23:0]   cost_r, cost_nxt;
  logic          done_r, done_nxt;
  spc_tok_t      tok_r, tok_nxt;
  logic [VW-1:0] tok_idx_r, tok_idx_nxt;
  logic [16:0]   sum;
  logic [24:0]   csum;
  logic [23:0]   csat;
  logic          is_self;

  assign is_self = (VW'(CELL_IDX) == src);

  // Candidate path through the picked vertex
  always_comb begin
    sum  = {1'b0, ctl.pick_len} + {1'b0, edge_len};
    csum = {1'b0, ctl.pick_cost} + {9'b0, edge_cost};
    csat = csum[24] ? SPC_COST_MAX : csum[23:0];
  end

  // Load, relax or hold the vertex state
  always_comb begin
    len_nxt  = len_r;
    cost_nxt = cost_r;
    done_nxt = done_r;
    if (ctl.init) begin
      len_nxt  = is_self ? 16'd0 : edge_len;
      cost_nxt = is_self ? 24'd0 : {8'd0, edge_cost};
      done_nxt = is_self || (CW'(CELL_IDX) >= n_active);
    end else if (ctl.relax) begin
      if (VW'(CELL_IDX) == pick_idx) begin
        done_nxt = 1'b1;
      end else if (!done_r && edge_len != SPC_NO_EDGE) begin
        if (sum < {1'b0, len_r}) begin
          len_nxt  = sum[15:0];
          cost_nxt = csat;
        end else if (sum == {1'b0, len_r} && csat < cost_r) begin
          cost_nxt = csat;
        end
      end
    end
  end

  // Take the token over when this vertex is strictly lower
  always_comb begin
    tok_nxt     = tok_i;
    tok_idx_nxt = tok_idx_i;
    if (tok_i.valid && !done_r && len_r < tok_i.low) begin
      tok_nxt.found = 1'b1;
      tok_nxt.low   = len_r;
      tok_nxt.cost  = cost_r;
      tok_idx_nxt   = VW'(CELL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b1;
      tok_r  <= '0;
    end else begin
      done_r <= done_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r     <= len_nxt;
    cost_r    <= cost_nxt;
    tok_idx_r <= tok_idx_nxt;
  end

  assign tok_o     = tok_r;
  assign tok_idx_o = tok_idx_r;
  assign len_o     = len_r;
  assign cost_o    = cost_r;

endmodule

>>> design/shortest_path_cost_tiebreak_core.sv
// Shortest path search with cost tie-break: sequencer, adjacency memory and vertex cell chain.
`timescale 1ns / 1ps
// An edge load writes the a-to-b entry when it is accepted and the b-to-a
// entry in S_LOAD2; a clear acts when it is accepted. A query reads the source
// row, then for every collected vertex sends a search token down the chain of
// MAX_VERTICES cells, one cell per cycle, and relaxes all cells in parallel from
// the picked row. Most of a query's time goes to the token's trip through the
// cell chain. A query whose source or destination lies beyond vertex_count goes
// straight to S_FINISH. A result waits in the output register; loads and clears
// are still taken meanwhile, and the next query holds in its last state until
// the register is free. No clearing pass after reset.
module shortest_path_cost_tiebreak_core import spc_pkg::*; #(
  parameter int MAX_VERTICES = SPC_MAX_VERTICES,
  localparam int VW = $clog2(MAX_VERTICES),
  localparam int CW = $clog2(MAX_VERTICES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_func,
  input  logic [VW-1:0] in_vertex_a,
  input  logic [VW-1:0] in_vertex_b,
  input  logic [15:0]   in_edge_dist,
  input  logic [15:0]   in_edge_cost,
  input  logic [VW-1:0] in_source_vertex,
  input  logic [VW-1:0] in_dest_vertex,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_reachable,
  output logic [15:0]   out_path_length,
  output logic [23:0]   out_path_cost,
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_wdata
);

  spc_state_t    state_r, state_nxt;
  logic [CW-1:0] vcount_r;
  logic [CW-1:0] n_active;
  logic [VW-1:0] a_r, b_r, src_r, dest_r, pick_r;
  logic [15:0]   dist_r, ecost_r, pick_len_r;
  logic [23:0]   pick_cost_r;
  logic          miss_r;
  logic          out_valid_r;
  logic          out_reach_r;
  logic [15:0]   out_len_r;
  logic [23:0]   out_cost_r;

  logic          accept;
  logic          ld_edge, ld_query, ld_miss, ld_pick, ld_out;
  logic          mem_clr, mem_wr;
  logic [VW-1:0] wr_row, wr_col, rd_row;
  logic [15:0]   wr_len, wr_cost;
  logic [15:0]   row_len  [MAX_VERTICES];
  logic [15:0]   row_cost [MAX_VERTICES];
  logic [15:0]   cell_len  [MAX_VERTICES];
  logic [23:0]   cell_cost [MAX_VERTICES];
  spc_tok_t      tok     [MAX_VERTICES+1];
  logic [VW-1:0] tok_idx [MAX_VERTICES+1];
  logic [MAX_VERTICES-1:0] tok_live;
  spc_ctl_t      ctl;
  spc_tok_t      tok_last;
  logic [15:0]   res_len;
  logic          res_reach;

  assign accept = in_valid && in_ready;

  // Clamp the vertex count into 1..MAX_VERTICES
  always_comb begin
    if (vcount_r == '0) begin
      n_active = CW'(1);
    end else if (vcount_r > CW'(MAX_VERTICES)) begin
      n_active = CW'(MAX_VERTICES);
    end else begin
      n_active = vcount_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= CW'(MAX_VERTICES);
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  assign tok_last = tok[MAX_VERTICES];

  // Sequencer: next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    ld_edge   = 1'b0;
    ld_query  = 1'b0;
    ld_miss   = 1'b0;
    ld_pick   = 1'b0;
    ld_out    = 1'b0;
    mem_clr   = 1'b0;
    mem_wr    = 1'b0;
    wr_row    = in_vertex_a;
    wr_col    = in_vertex_b;
    wr_len    = in_edge_dist;
    wr_cost   = in_edge_cost;
    rd_row    = in_source_vertex;
    ctl       = '0;
    ctl.pick_len  = pick_len_r;
    ctl.pick_cost = pick_cost_r;
    tok[0]        = '0;
    tok[0].low    = SPC_NO_EDGE;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          case (in_func)
            FUNC_LOAD: begin
              if ({1'b0, in_vertex_a} < (VW+1)'(n_active) &&
                  {1'b0, in_vertex_b} < (VW+1)'(n_active)) begin
                mem_wr    = 1'b1;
                ld_edge   = 1'b1;
                state_nxt = S_LOAD2;
              end
            end
            FUNC_QUERY: begin
              ld_query = 1'b1;
              if ({1'b0, in_source_vertex} < (VW+1)'(n_active) &&
                  {1'b0, in_dest_vertex} < (VW+1)'(n_active)) begin
                state_nxt = S_INIT;
              end else begin
                ld_miss   = 1'b1;
                state_nxt = S_FINISH;
              end
            end
            FUNC_CLEAR: mem_clr = 1'b1;
            default: ;
          endcase
        end
      end
      S_LOAD2: begin
        mem_wr    = 1'b1;
        wr_row    = b_r;
        wr_col    = a_r;
        wr_len    = dist_r;
        wr_cost   = ecost_r;
        state_nxt = S_IDLE;
      end
      S_INIT: begin
        ctl.init  = 1'b1;
        state_nxt = S_SCAN_GO;
      end
      S_SCAN_GO: begin
        tok[0].valid = 1'b1;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        rd_row = tok_idx[MAX_VERTICES];
        if (tok_last.valid) begin
          if (tok_last.found) begin
            ld_pick   = 1'b1;
            state_nxt = S_RELAX;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_RELAX: begin
        ctl.relax = 1'b1;
        state_nxt = S_SCAN_GO;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          ld_out    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold edge, query and pick operands
  always_ff @(posedge clk) begin
    if (ld_edge) begin
      a_r     <= in_vertex_a;
      b_r     <= in_vertex_b;
      dist_r  <= in_edge_dist;
      ecost_r <= in_edge_cost;
    end
    if (ld_query) begin
      src_r  <= in_source_vertex;
      dest_r <= in_dest_vertex;
      miss_r <= ld_miss;
    end
    if (ld_pick) begin
      pick_r      <= tok_idx[MAX_VERTICES];
      pick_len_r  <= tok_last.low;
      pick_cost_r <= tok_last.cost;
    end
  end

  assign tok_idx[0] = '0;

  spc_mem #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (mem_clr),
    .wr_en   (mem_wr),
    .wr_row  (wr_row),
    .wr_col  (wr_col),
    .wr_len  (wr_len),
    .wr_cost (wr_cost),
    .rd_row  (rd_row),
    .rd_len  (row_len),
    .rd_cost (row_cost)
  );

  // Row of vertex cells, token running from vertex 0 upwards
  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    spc_cell #(
      .MAX_VERTICES(MAX_VERTICES),
      .CELL_IDX    (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .src       (src_r),
      .pick_idx  (pick_r),
      .n_active  (n_active),
      .edge_len  (row_len[g]),
      .edge_cost (row_cost[g]),
      .tok_i     (tok[g]),
      .tok_idx_i (tok_idx[g]),
      .tok_o     (tok[g+1]),
      .tok_idx_o (tok_idx[g+1]),
      .len_o     (cell_len[g]),
      .cost_o    (cell_cost[g])
    );
    assign tok_live[g] = tok[g+1].valid;
  end

  // Form the result from the destination cell
  assign res_len   = miss_r ? SPC_NO_EDGE : cell_len[dest_r];
  assign res_reach = (res_len != SPC_NO_EDGE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_reach_r <= res_reach;
      out_len_r   <= res_len;
      out_cost_r  <= res_reach ? cell_cost[dest_r] : 24'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reachable   = out_reach_r;
  assign out_path_length = out_len_r;
  assign out_path_cost   = out_cost_r;

`ifndef ASSERT_OFF
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_live))
    else $error("more than one search token in the cell chain");

  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_last.valid |-> state_r == S_SCAN)
    else $error("search token left the chain outside a scan");

  a_relax_after_pick: assert property (@(posedge clk) disable iff (!rst_n)
    ld_pick |=> state_r == S_RELAX && pick_len_r != SPC_NO_EDGE)
    else $error("relaxation without a valid picked vertex");

  a_miss_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ld_miss |=> state_r == S_FINISH && miss_r)
    else $error("out-of-range query did not go straight to finish");
`endif

endmodule

>>> tb/sv/tb_shortest_path_cost_tiebreak_core.sv
// Self-checking testbench for the shortest path cost core with a scoreboard class.
`timescale 1ns / 1ps
module tb_shortest_path_cost_tiebreak_core;
  import spc_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         NV = SPC_MAX_VERTICES;
  localparam longint     CYCLE_LIMIT = 3000000;
  localparam int         LONG_HOLD = 3000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_func;
  logic [5:0]  in_vertex_a;
  logic [5:0]  in_vertex_b;
  logic [15:0] in_edge_dist;
  logic [15:0] in_edge_cost;
  logic [5:0]  in_source_vertex;
  logic [5:0]  in_dest_vertex;
  logic        out_valid;
  logic        out_ready;
  logic        out_reachable;
  logic [15:0] out_path_length;
  logic [23:0] out_path_cost;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;

  typedef struct {
    logic        reachable;
    logic [15:0] length;
    logic [23:0] cost;
  } route_t;

  // Mirror of the graph and the expected route results
  class route_scoreboard;
    logic [15:0] len_m[NV][NV];
    logic [15:0] cost_m[NV][NV];
    int unsigned vcount;
    route_t      pending[$];
    bit          failed;

    function void clear_graph();
      foreach (len_m[i, j]) begin
        len_m[i][j]  = SPC_NO_EDGE;
        cost_m[i][j] = SPC_NO_EDGE;
      end
    endfunction

    function void set_count(logic [6:0] v);
      vcount = (v == 0) ? 1 : ((v > NV) ? NV : v);
    endfunction

    // Dijkstra with lowest-index pick and cheaper-cost tie-break
    function route_t search_route(int unsigned src, int unsigned dst);
      int unsigned blen[NV];
      int unsigned bcost[NV];
      bit          done[NV];
      int unsigned pick, low, sum, csum;
      bit          found;
      route_t      r;
      for (int v = 0; v < vcount; v++) begin
        blen[v]  = len_m[src][v];
        bcost[v] = cost_m[src][v];
        done[v]  = 1'b0;
      end
      blen[src]  = 0;
      bcost[src] = 0;
      done[src]  = 1'b1;
      forever begin
        found = 1'b0;
        low   = SPC_NO_EDGE;
        pick  = 0;
        for (int v = 0; v < vcount; v++) begin
          if (!done[v] && blen[v] < low) begin
            low   = blen[v];
            pick  = v;
            found = 1'b1;
          end
        end
        if (!found) break;
        done[pick] = 1'b1;
        for (int w = 0; w < vcount; w++) begin
          if (done[w] || len_m[pick][w] == SPC_NO_EDGE) continue;
          sum  = blen[pick] + len_m[pick][w];
          csum = bcost[pick] + cost_m[pick][w];
          if (csum > SPC_COST_MAX) csum = SPC_COST_MAX;
          if (sum < blen[w]) begin
            blen[w]  = sum;
            bcost[w] = csum;
          end else if (sum == blen[w] && csum < bcost[w]) begin
            bcost[w] = csum;
          end
        end
      end
      if (blen[dst] < SPC_NO_EDGE) begin
        r.reachable = 1'b1;
        r.length    = 16'(blen[dst]);
        r.cost      = 24'(bcost[dst]);
      end else begin
        r.reachable = 1'b0;
        r.length    = SPC_NO_EDGE;
        r.cost      = '0;
      end
      return r;
    endfunction

    function void note_input(logic [1:0] f, logic [5:0] a, logic [5:0] b,
                             logic [15:0] d, logic [15:0] c,
                             logic [5:0] s, logic [5:0] t);
      route_t r;
      if (f == FUNC_LOAD) begin
        if (a < vcount && b < vcount) begin
          len_m[a][b]  = d;
          cost_m[a][b] = c;
          len_m[b][a]  = d;
          cost_m[b][a] = c;
        end
      end else if (f == FUNC_CLEAR) begin
        clear_graph();
      end else if (f == FUNC_QUERY) begin
        if (s < vcount && t < vcount) begin
          r = search_route(s, t);
        end else begin
          r.reachable = 1'b0;
          r.length    = SPC_NO_EDGE;
          r.cost      = '0;
        end
        pending.push_back(r);
      end
    endfunction

    function void check_result(logic re, logic [15:0] l, logic [23:0] c);
      route_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: reachable %0d length %0d cost %0d", re, l, c);
        failed = 1'b1;
        return;
      end
      e = pending.pop_front();
      if (re !== e.reachable) begin
        $error("reachable: expected %0d, got %0d", e.reachable, re);
        failed = 1'b1;
      end
      if (l !== e.length) begin
        $error("path_length: expected %0d, got %0d", e.length, l);
        failed = 1'b1;
      end
      if (c !== e.cost) begin
        $error("path_cost: expected %0d, got %0d", e.cost, c);
        failed = 1'b1;
      end
    endfunction
  endclass

  route_scoreboard sb = new();
  longint cycles = 0;
  int     sent = 0;
  int     results_seen = 0;
  int     stall_left = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;

  shortest_path_cost_tiebreak_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .in_edge_dist(in_edge_dist), .in_edge_cost(in_edge_cost),
    .in_source_vertex(in_source_vertex), .in_dest_vertex(in_dest_vertex),
    .out_valid(out_valid), .out_ready(out_ready), .out_reachable(out_reachable),
    .out_path_length(out_path_length), .out_path_cost(out_path_cost),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: check each transaction, stall at random, hold off once for long
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_result(out_reachable, out_path_length, out_path_cost);
        results_seen++;
        stall_left = ((results_seen / 25) % 2 == 1) ? 0 : $urandom_range(0, 4);
        if (results_seen == 12 && !hold_done) begin
          hold_left = LONG_HOLD;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one transaction and wait for it to be taken
  task automatic send_item(logic [1:0] f, logic [5:0] a, logic [5:0] b,
                           logic [15:0] d, logic [15:0] c,
                           logic [5:0] s, logic [5:0] t);
    int gap;
    gap = ((sent / 20) % 3 == 2) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= f;
    in_vertex_a      <= a;
    in_vertex_b      <= b;
    in_edge_dist     <= d;
    in_edge_cost     <= c;
    in_source_vertex <= s;
    in_dest_vertex   <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(f, a, b, d, c, s, t);
    sent++;
  endtask

  task automatic load_edge(int a, int b, int d, int c);
    send_item(FUNC_LOAD, 6'(a), 6'(b), 16'(d), 16'(c), 6'($urandom), 6'($urandom));
  endtask

  task automatic query(int s, int t);
    send_item(FUNC_QUERY, 6'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
              6'(s), 6'(t));
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(logic [6:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_count(v);
  endtask

  // Random mix with graph-shaped content
  task automatic random_item();
    int unsigned pct, hi;
    logic [5:0]  a, b;
    logic [15:0] d, c;
    pct = $urandom_range(0, 99);
    hi  = sb.vcount - 1;
    a   = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, hi));
    b   = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, hi));
    d   = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535)) :
                                        16'($urandom_range(0, 40));
    c   = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535)) :
                                        16'($urandom_range(0, 20));
    if (pct < 58)      load_edge(a, b, d, c);
    else if (pct < 92) query(a, b);
    else if (pct < 96) send_item(FUNC_CLEAR, a, b, d, c, a, b);
    else               send_item(FUNC_UNUSED, a, b, d, c, a, b);
  endtask

  initial begin
    logic [6:0] counts[8] = '{7'd1, 7'd0, 7'd127, 7'd8, 7'd5, 7'd64, 7'd3, 7'd33};
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_func    <= FUNC_LOAD;
    in_vertex_a <= '0;
    in_vertex_b <= '0;
    in_edge_dist <= '0;
    in_edge_cost <= '0;
    in_source_vertex <= '0;
    in_dest_vertex <= '0;
    out_ready  <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    sb.clear_graph();
    sb.set_count(7'd64);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ties, long sums, self loops, edge removal, unknown func
    write_count(7'd64);
    load_edge(0, 1, 10, 5);
    load_edge(1, 2, 10, 7);
    load_edge(0, 2, 20, 30);
    query(0, 2);
    load_edge(2, 63, 65534, 65534);
    query(0, 63);
    load_edge(3, 3, 1, 0);
    query(3, 3);
    query(63, 63);
    load_edge(62, 63, 0, 0);
    query(62, 2);
    send_item(FUNC_UNUSED, 6'h3f, 6'h3f, 16'hffff, 16'hffff, 6'h3f, 6'h3f);
    load_edge(5, 6, 9, 9);
    load_edge(5, 6, 65535, 0);
    query(5, 6);
    query(0, 5);
    send_item(FUNC_CLEAR, 6'd0, 6'd0, 16'd0, 16'd0, 6'd0, 6'd0);
    query(0, 1);
    write_count(7'd4);
    load_edge(3, 10, 1, 1);
    load_edge(0, 3, 4, 4);
    query(0, 10);
    query(10, 0);
    query(3, 0);

    // Random phases over several vertex counts
    foreach (counts[k]) begin
      write_count(counts[k]);
      if ($urandom_range(0, 1) == 1) send_item(FUNC_CLEAR, 6'd0, 6'd0, 16'd0, 16'd0, 6'd0, 6'd0);
      repeat (16) random_item();
    end
    drain();
    repeat (5000) @(posedge clk);
    if (!sb.failed && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
